// ===== rtl/core/rkt_pkg.sv =====
package rkt_pkg;

  localparam int unsigned KEY_W = 22;
  localparam int unsigned OUT_W = 16;

  localparam logic [1:0] OP_REF   = 2'd0;
  localparam logic [1:0] OP_UNREF = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_LOOK,
    FSM_EXEC
  } fsm_state_t;

  // Broadcast from the controller to every cell of the row.
  typedef struct packed {
    logic             lookup;
    logic             update;
    logic             hit_any;
    logic [1:0]       op;
    logic [KEY_W-1:0] key;
  } cell_cmd_t;

endpackage

// ===== rtl/core/rkt_cell.sv =====
module rkt_cell #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  rkt_pkg::cell_cmd_t      cmd,
  input  logic                    free_in,
  output logic                    free_out,
  input  logic                    hit_in,
  output logic                    hit_out,
  input  logic [COUNT_BITS-1:0]   cnt_in,
  output logic [COUNT_BITS-1:0]   cnt_out
);

  logic [rkt_pkg::KEY_W-1:0] key_r;
  logic [COUNT_BITS-1:0]     count_r;
  logic                      valid_r;
  logic                      hit_r;
  logic                      first_r;
  logic                      hit;

  assign hit      = valid_r && (key_r == cmd.key);
  assign free_out = free_in | ~valid_r;
  assign hit_out  = hit_in | hit;
  assign cnt_out  = cnt_in | (hit ? count_r : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      hit_r   <= 1'b0;
      first_r <= 1'b0;
    end else begin
      if (cmd.lookup) begin
        hit_r   <= hit;
        first_r <= ~valid_r & ~free_in;
      end
      if (cmd.update) begin
        if (hit_r) begin
          if (cmd.op == rkt_pkg::OP_REF) begin
            if (count_r != {COUNT_BITS{1'b1}}) begin
              count_r <= count_r + COUNT_BITS'(1);
            end
          end else if (cmd.op == rkt_pkg::OP_UNREF) begin
            if (count_r <= COUNT_BITS'(1)) begin
              count_r <= '0;
              valid_r <= 1'b0;
            end else begin
              count_r <= count_r - COUNT_BITS'(1);
            end
          end
        end else if (first_r && !cmd.hit_any && cmd.op == rkt_pkg::OP_REF) begin
          valid_r <= 1'b1;
          key_r   <= cmd.key;
          count_r <= COUNT_BITS'(1);
        end
      end
    end
  end

endmodule

// ===== rtl/core/refcounted_key_table.sv =====
// Each input transfer runs a lookup pass (LOOK) and an update pass (EXEC)
// through the row of table cells, and the result is registered onto out_valid.
// A new item waits for the last one's update pass, which a stalled output holds.
// Reset (rst_n low, synchronous) clears all valid marks at once; no clearing
// pass is needed and the block takes items right after reset.
module refcounted_key_table #(
  parameter int unsigned TABLE_ENTRIES = 16,
  parameter int unsigned COUNT_BITS    = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_op,
  input  logic [rkt_pkg::KEY_W-1:0]   in_proc_id,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rkt_pkg::OUT_W-1:0]   out_ref_count,
  output logic [1:0]                  out_status
);

  rkt_pkg::fsm_state_t state_r, state_nxt;

  logic [1:0]                op_r;
  logic [rkt_pkg::KEY_W-1:0] key_r;
  logic                      hit_any_r;
  logic                      free_any_r;
  logic [COUNT_BITS-1:0]     hit_cnt_r;
  logic                      out_valid_r;
  logic [rkt_pkg::OUT_W-1:0] out_cnt_r;
  logic [1:0]                out_status_r;

  logic                      in_xfer;
  logic                      done;
  rkt_pkg::cell_cmd_t        cmd;

  logic [TABLE_ENTRIES:0]    free_chain;
  logic [TABLE_ENTRIES:0]    hit_chain;
  logic [COUNT_BITS-1:0]     cnt_chain [TABLE_ENTRIES+1];

  logic [COUNT_BITS-1:0]     res_cnt;
  logic [1:0]                res_status;
  logic [32:0]               res_wide;

  assign free_chain[0] = 1'b0;
  assign hit_chain[0]  = 1'b0;
  assign cnt_chain[0]  = '0;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    rkt_cell #(.COUNT_BITS(COUNT_BITS)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .free_in  (free_chain[i]),
      .free_out (free_chain[i+1]),
      .hit_in   (hit_chain[i]),
      .hit_out  (hit_chain[i+1]),
      .cnt_in   (cnt_chain[i]),
      .cnt_out  (cnt_chain[i+1])
    );
  end

  assign done    = (state_r == rkt_pkg::FSM_EXEC) && (!out_valid_r || !out_stall);
  assign in_xfer = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rkt_pkg::FSM_IDLE: begin
        if (in_xfer) state_nxt = rkt_pkg::FSM_LOOK;
      end
      rkt_pkg::FSM_LOOK: begin
        state_nxt = rkt_pkg::FSM_EXEC;
      end
      rkt_pkg::FSM_EXEC: begin
        if (done) state_nxt = in_xfer ? rkt_pkg::FSM_LOOK : rkt_pkg::FSM_IDLE;
      end
      default: state_nxt = rkt_pkg::FSM_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = !((state_r == rkt_pkg::FSM_IDLE) || done);
    cmd.lookup  = (state_r == rkt_pkg::FSM_LOOK);
    cmd.update  = done;
    cmd.hit_any = hit_any_r;
    cmd.op      = op_r;
    cmd.key     = key_r;
  end

  always_comb begin
    res_cnt    = '0;
    res_status = rkt_pkg::ST_OK;
    unique case (op_r)
      rkt_pkg::OP_REF: begin
        if (hit_any_r) begin
          res_cnt = (hit_cnt_r == {COUNT_BITS{1'b1}}) ? hit_cnt_r
                                                      : hit_cnt_r + COUNT_BITS'(1);
        end else if (free_any_r) begin
          res_cnt = COUNT_BITS'(1);
        end else begin
          res_status = rkt_pkg::ST_FULL;
        end
      end
      rkt_pkg::OP_UNREF: begin
        if (hit_any_r) begin
          res_cnt = (hit_cnt_r <= COUNT_BITS'(1)) ? '0 : hit_cnt_r - COUNT_BITS'(1);
        end else begin
          res_status = rkt_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        if (hit_any_r) begin
          res_cnt = hit_cnt_r;
        end else begin
          res_status = rkt_pkg::ST_NOT_FOUND;
        end
      end
    endcase
    res_wide = 33'(res_cnt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rkt_pkg::FSM_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (done) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r  <= in_op;
      key_r <= in_proc_id;
    end
    if (state_r == rkt_pkg::FSM_LOOK) begin
      hit_any_r  <= hit_chain[TABLE_ENTRIES];
      free_any_r <= free_chain[TABLE_ENTRIES];
      hit_cnt_r  <= cnt_chain[TABLE_ENTRIES];
    end
    if (done) begin
      out_cnt_r    <= (res_wide > 33'h0FFFF) ? {rkt_pkg::OUT_W{1'b1}}
                                             : res_wide[rkt_pkg::OUT_W-1:0];
      out_status_r <= res_status;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_ref_count = out_cnt_r;
  assign out_status    = out_status_r;

endmodule
